// ===== rtl/keyframe_pose_interpolator_assert.svh =====
// Assertion macros for the keyframe pose interpolator.
// Included by keyframe_pose_interpolator, which checks its own control logic.
`ifndef KEYFRAME_POSE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_POSE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kpi_pkg.sv =====
// Shared types, constants and helpers of the keyframe pose interpolator.
// No dependencies.
package kpi_pkg;

    localparam logic signed [33:0] PI_Q        = 34'sd210828714;
    localparam logic signed [33:0] TWO_PI_Q    = 34'sd421657428;
    localparam logic signed [25:0] DEG2RAD_MUL = 26'sd18740330;
    localparam logic [16:0]        THETA_ONE   = 17'd65536;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_START_Z     = 3'd2,
        CFG_START_ROLL  = 3'd3,
        CFG_START_PITCH = 3'd4,
        CFG_START_YAW   = 3'd5,
        CFG_KEY_COUNT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        time_q;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] ang_r;
        logic signed [31:0] ang_p;
        logic signed [31:0] ang_y;
    } t_key;

    typedef struct packed {
        logic we;
        t_key data;
    } t_key_wr;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/keyframe_pose_interpolator.sv =====
// Keyframe pose interpolator: one item in flight; a load stalls the input until its key is
// written. A query at or after the last key returns that key; otherwise it scans for the segment,
// reads its two keys (none before the first key), divides for the fraction (skipped for an empty
// segment), blends the positions, then the angles with their wrap steps, and waits on output
// stalls; the next item is taken the cycle after the result goes to the output register.
// Reset clears control, zeroes the start pose, sets key_count to one; not the table.
module keyframe_pose_interpolator #(
    parameter int MAX_KEYS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [5:0]         i_key_index,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_z,
    input  logic signed [27:0] i_key_roll_deg,
    input  logic signed [27:0] i_key_pitch_deg,
    input  logic signed [27:0] i_key_yaw_deg,
    input  logic [31:0]        i_query_time,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_roll,
    output logic signed [31:0] o_pitch,
    output logic signed [31:0] o_yaw,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

`include "keyframe_pose_interpolator_assert.svh"

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    // channels 0..2 are positions, 3..5 angles
    localparam logic [2:0] CH_ANG0 = 3'd3;
    localparam logic [2:0] CH_LAST = 3'd5;
    localparam logic [1:0] DEG_LAST = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_RND,
        ST_LD_WR,
        ST_Q_LAST,
        ST_Q_FIRST,
        ST_Q_SCAN,
        ST_Q_RD0,
        ST_Q_RD1,
        ST_Q_THETA,
        ST_Q_DIV,
        ST_L_SET,
        ST_L_WRAP1,
        ST_L_MUL,
        ST_L_ADD,
        ST_L_WRAP2,
        ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_start [6];
    logic [6:0]         r_key_count;

    // item working registers
    logic [2:0]         r_j;
    logic [31:0]        r_t;
    logic [31:0]        r_t0;
    logic [31:0]        r_t1;
    logic [AW-1:0]      r_k;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      n_addr;
    logic signed [31:0] r_v0 [6];
    logic signed [31:0] r_v1 [6];
    logic signed [31:0] r_res [6];
    logic [16:0]        r_theta;
    logic signed [33:0] r_ma;
    logic signed [59:0] r_prod;
    logic signed [33:0] r_w;
    logic [5:0]         r_kidx;
    logic               r_kvalid;
    logic [31:0]        r_ktime;
    logic signed [31:0] r_kpos [3];
    logic signed [27:0] r_deg [3];
    logic signed [31:0] r_rad [3];

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out [6];

    // key count clamped to 1..MAX_KEYS
    logic [AW:0]        w_n;
    logic [AW-1:0]      w_last;
    kpi_pkg::t_key      w_rd;
    kpi_pkg::t_key_wr   w_wr;
    logic               w_in_acc;
    logic               w_adv;
    logic [AW-1:0]      w_k1;
    logic [AW:0]        w_k1p2;
    logic [AW:0]        w_k2;
    logic               w_cont;
    logic               w_th_skip;
    logic               w_div_start;
    logic               w_div_done;
    logic [47:0]        w_div_quo;
    logic signed [33:0] w_ma;
    logic signed [25:0] w_mb;
    logic signed [59:0] w_prod;
    logic signed [59:0] w_rnd;
    logic signed [59:0] w_drnd;
    logic signed [45:0] w_sum;
    logic               w_in_range;
    logic               w_out_free;

    always_comb begin
        if (r_key_count == '0) begin
            w_n = (AW+1)'(1);
        end else if (32'(r_key_count) > MAX_KEYS) begin
            w_n = (AW+1)'(MAX_KEYS);
        end else begin
            w_n = (AW+1)'(r_key_count);
        end
    end
    assign w_last = AW'(w_n - 1'b1);

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // scan step: advance while the query time has reached the next key
    assign w_adv  = (r_t >= w_rd.time_q);
    assign w_k1   = r_k + 1'b1;
    assign w_k1p2 = {1'b0, w_k1} + (AW+1)'(2);
    assign w_k2   = {1'b0, r_k} + (AW+1)'(2);
    assign w_cont = (w_k1p2 < w_n);

    // read address of the next cycle, read by the table through its output register
    always_comb begin
        n_addr = r_addr;
        case (r_state)
            ST_IDLE:    n_addr = w_last;
            ST_Q_LAST:  n_addr = '0;
            ST_Q_FIRST: n_addr = (w_n > (AW+1)'(2)) ? AW'(1) : '0;
            ST_Q_SCAN:  n_addr = w_adv ? (w_cont ? AW'(w_k1 + 1'b1) : w_k1) : r_k;
            ST_Q_RD0:   n_addr = w_k1;
            default:    n_addr = r_addr;
        endcase
    end

    assign w_wr.we         = (r_state == ST_LD_WR) && r_kvalid;
    assign w_wr.data.time_q = r_ktime;
    assign w_wr.data.pos_x = r_kpos[0];
    assign w_wr.data.pos_y = r_kpos[1];
    assign w_wr.data.pos_z = r_kpos[2];
    assign w_wr.data.ang_r = r_rad[0];
    assign w_wr.data.ang_p = r_rad[1];
    assign w_wr.data.ang_y = r_rad[2];

    kpi_keymem #(
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_keymem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_waddr (AW'(r_kidx)),
        .i_raddr (n_addr),
        .o_rdata (w_rd)
    );

    // fraction is zero for an empty or reversed segment, or a query time before its start
    assign w_th_skip   = (r_t1 <= r_t0) || (r_t < r_t0);
    assign w_div_start = (r_state == ST_Q_THETA) && !w_th_skip;

    kpi_div #(
        .NUM_W (48),
        .DEN_W (32)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_t - r_t0, 16'd0}),
        .i_den   (r_t1 - r_t0),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // one shared multiplier: degree conversion on loads, blend on queries
    assign w_ma   = (r_state == ST_LD_MUL) ? 34'(r_deg[r_j[1:0]]) : r_ma;
    assign w_mb   = (r_state == ST_LD_MUL) ? kpi_pkg::DEG2RAD_MUL : $signed({9'd0, r_theta});
    assign w_prod = w_ma * w_mb;

    assign w_drnd = r_prod + 60'sd524288;
    assign w_rnd  = r_prod + 60'sd32768;
    assign w_sum  = 46'(r_v0[r_j]) + 46'(w_rnd >>> 16);

    assign w_in_range = (r_w <= kpi_pkg::PI_Q) && (r_w >= -kpi_pkg::PI_Q);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_key_count <= 7'd1;
            for (int i = 0; i < 6; i++) begin
                r_start[i] <= '0;
            end
        end else begin
            // configuration must arrive only while idle; the block itself does not enforce it
            if (i_cfg_valid) begin
                unique case (i_cfg_index) inside
                    kpi_pkg::CFG_START_X, kpi_pkg::CFG_START_Y, kpi_pkg::CFG_START_Z,
                    kpi_pkg::CFG_START_ROLL, kpi_pkg::CFG_START_PITCH,
                    kpi_pkg::CFG_START_YAW: begin
                        r_start[i_cfg_index] <= i_cfg_data;
                    end
                    kpi_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // drop the taken beat; ST_OUT refills the register itself
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_j <= '0;
                        if (i_action == kpi_pkg::ACT_LOAD) begin
                            r_kidx    <= i_key_index;
                            r_kvalid  <= (32'(i_key_index) < MAX_KEYS);
                            r_ktime   <= i_key_time;
                            r_kpos[0] <= i_key_x;
                            r_kpos[1] <= i_key_y;
                            r_kpos[2] <= i_key_z;
                            r_deg[0]  <= i_key_roll_deg;
                            r_deg[1]  <= i_key_pitch_deg;
                            r_deg[2]  <= i_key_yaw_deg;
                            r_state   <= ST_LD_MUL;
                        end else begin
                            r_t     <= i_query_time;
                            r_state <= ST_Q_LAST;
                        end
                    end
                end
                ST_LD_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_LD_RND;
                end
                ST_LD_RND: begin
                    r_rad[r_j[1:0]] <= kpi_pkg::sat32(48'(w_drnd >>> 20));
                    if (r_j[1:0] == DEG_LAST) begin
                        r_state <= ST_LD_WR;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_LD_MUL;
                    end
                end
                ST_LD_WR: r_state <= ST_IDLE;
                ST_Q_LAST: begin
                    // hold the last key as the result; used as is at or past its time
                    r_res[0] <= w_rd.pos_x;
                    r_res[1] <= w_rd.pos_y;
                    r_res[2] <= w_rd.pos_z;
                    r_res[3] <= w_rd.ang_r;
                    r_res[4] <= w_rd.ang_p;
                    r_res[5] <= w_rd.ang_y;
                    r_state  <= (r_t >= w_rd.time_q) ? ST_OUT : ST_Q_FIRST;
                end
                ST_Q_FIRST: begin
                    if (r_t <= w_rd.time_q) begin
                        // at or before the first key: blend from the start pose
                        for (int i = 0; i < 6; i++) begin
                            r_v0[i] <= r_start[i];
                        end
                        r_v1[0] <= w_rd.pos_x;
                        r_v1[1] <= w_rd.pos_y;
                        r_v1[2] <= w_rd.pos_z;
                        r_v1[3] <= w_rd.ang_r;
                        r_v1[4] <= w_rd.ang_p;
                        r_v1[5] <= w_rd.ang_y;
                        r_t0    <= '0;
                        r_t1    <= w_rd.time_q;
                        r_state <= ST_Q_THETA;
                    end else begin
                        r_k     <= '0;
                        r_state <= (w_n > (AW+1)'(2)) ? ST_Q_SCAN : ST_Q_RD0;
                    end
                end
                ST_Q_SCAN: begin
                    if (w_adv) begin
                        r_k <= w_k1;
                        if (!w_cont) begin
                            r_state <= ST_Q_RD0;
                        end
                    end else begin
                        r_state <= ST_Q_RD0;
                    end
                end
                ST_Q_RD0: begin
                    r_v0[0] <= w_rd.pos_x;
                    r_v0[1] <= w_rd.pos_y;
                    r_v0[2] <= w_rd.pos_z;
                    r_v0[3] <= w_rd.ang_r;
                    r_v0[4] <= w_rd.ang_p;
                    r_v0[5] <= w_rd.ang_y;
                    r_t0    <= w_rd.time_q;
                    r_state <= ST_Q_RD1;
                end
                ST_Q_RD1: begin
                    r_v1[0] <= w_rd.pos_x;
                    r_v1[1] <= w_rd.pos_y;
                    r_v1[2] <= w_rd.pos_z;
                    r_v1[3] <= w_rd.ang_r;
                    r_v1[4] <= w_rd.ang_p;
                    r_v1[5] <= w_rd.ang_y;
                    r_t1    <= w_rd.time_q;
                    r_state <= ST_Q_THETA;
                end
                ST_Q_THETA: begin
                    r_j <= '0;
                    if (w_th_skip) begin
                        r_theta <= '0;
                        r_state <= ST_L_SET;
                    end else begin
                        r_state <= ST_Q_DIV;
                    end
                end
                ST_Q_DIV: begin
                    if (w_div_done) begin
                        // clamp the fraction to one
                        r_theta <= (w_div_quo > 48'(kpi_pkg::THETA_ONE)) ?
                                   kpi_pkg::THETA_ONE : w_div_quo[16:0];
                        r_state <= ST_L_SET;
                    end
                end
                ST_L_SET: begin
                    if (r_j >= CH_ANG0) begin
                        r_w     <= 34'(r_v1[r_j]) - 34'(r_v0[r_j]);
                        r_state <= ST_L_WRAP1;
                    end else begin
                        r_ma    <= 34'(r_v1[r_j]) - 34'(r_v0[r_j]);
                        r_state <= ST_L_MUL;
                    end
                end
                ST_L_WRAP1: begin
                    // one turn per cycle until the difference is the shortest path
                    if (r_w > kpi_pkg::PI_Q) begin
                        r_w <= r_w - kpi_pkg::TWO_PI_Q;
                    end else if (r_w < -kpi_pkg::PI_Q) begin
                        r_w <= r_w + kpi_pkg::TWO_PI_Q;
                    end else begin
                        r_ma    <= r_w;
                        r_state <= ST_L_MUL;
                    end
                end
                ST_L_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_L_ADD;
                end
                ST_L_ADD: begin
                    if (r_j >= CH_ANG0) begin
                        r_w     <= 34'(w_sum);
                        r_state <= ST_L_WRAP2;
                    end else begin
                        r_res[r_j] <= kpi_pkg::sat32(48'(w_sum));
                        r_j        <= r_j + 1'b1;
                        r_state    <= ST_L_SET;
                    end
                end
                ST_L_WRAP2: begin
                    if (r_w > kpi_pkg::PI_Q) begin
                        r_w <= r_w - kpi_pkg::TWO_PI_Q;
                    end else if (r_w < -kpi_pkg::PI_Q) begin
                        r_w <= r_w + kpi_pkg::TWO_PI_Q;
                    end else begin
                        r_res[r_j] <= r_w[31:0];
                        if (r_j == CH_LAST) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_L_SET;
                        end
                    end
                end
                ST_OUT: begin
                    // hand the beat to the output register once it is free
                    if (w_out_free) begin
                        for (int i = 0; i < 6; i++) begin
                            r_out[i] <= r_res[i];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out[0];
    assign o_pos_y     = r_out[1];
    assign o_pos_z     = r_out[2];
    assign o_roll      = r_out[3];
    assign o_pitch     = r_out[4];
    assign o_yaw       = r_out[5];

    `KPI_ASSERT_IMP(a_theta_le_one, i_clk, i_rst_n, r_state == ST_L_MUL, r_theta <= kpi_pkg::THETA_ONE, "fraction above one")
    `KPI_ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n, w_div_done, r_state == ST_Q_DIV, "divider finished outside its wait")
    `KPI_ASSERT_NXT(a_query_start, i_clk, i_rst_n, w_in_acc && (i_action == kpi_pkg::ACT_QUERY), r_state == ST_Q_LAST, "query did not start with the last key")
    `KPI_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == ST_Q_SCAN, w_k2 < w_n, "segment scan past the last segment")
    `KPI_ASSERT_IMP(a_angle_wrapped, i_clk, i_rst_n, (r_state == ST_L_MUL) && (r_j >= CH_ANG0), w_in_range || (r_ma == r_w), "angle step not wrapped")

endmodule

// ===== rtl/kpi_keymem.sv =====
// Keyframe table: one synchronous memory, one write and one read port.
// Depends on kpi_pkg for the entry type.
module kpi_keymem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic           i_clk,
    input  kpi_pkg::t_key_wr i_wr,
    input  logic [AW-1:0]  i_waddr,
    input  logic [AW-1:0]  i_raddr,
    output kpi_pkg::t_key  o_rdata
);

    kpi_pkg::t_key r_mem [DEPTH];
    kpi_pkg::t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kpi_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; used for the interpolation fraction.
module kpi_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W+1:0] w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge    = !w_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out of the top of r_quo, shift quotient bits in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== tb/tb_keyframe_pose_interpolator.sv =====
// Self-checking testbench of keyframe_pose_interpolator: loads, pose queries, register writes.
// Depends on kpi_pkg and the keyframe_pose_interpolator RTL only.
module tb_keyframe_pose_interpolator;

    localparam int     NKEYS   = 64;
    localparam longint PI_L    = 64'sd210828714;
    localparam longint TWOPI_L = 64'sd421657428;
    localparam longint DEG_MUL = 64'sd18740330;
    localparam longint ONE_Q   = 64'sd65536;
    // Cycles to let a load finish (or any query) once nothing is awaited.
    localparam int     SETTLE  = 300;

    // One pose: x, y, z, roll, pitch, yaw.
    typedef logic [5:0][31:0] t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = kpi_pkg::ACT_LOAD;
    logic [5:0]         i_key_index = '0;
    logic [31:0]        i_key_time = '0;
    logic signed [31:0] i_key_x = '0;
    logic signed [31:0] i_key_y = '0;
    logic signed [31:0] i_key_z = '0;
    logic signed [27:0] i_key_roll_deg = '0;
    logic signed [27:0] i_key_pitch_deg = '0;
    logic signed [27:0] i_key_yaw_deg = '0;
    logic [31:0]        i_query_time = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_roll, o_pitch, o_yaw;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // Shadow copy of the key table and the start pose.
    logic [31:0]        key_time_tab [NKEYS];
    logic signed [31:0] key_pos_tab [NKEYS][3];
    logic signed [31:0] key_rad_tab [NKEYS][3];
    logic signed [31:0] start_pos [3];
    logic signed [31:0] start_rad [3];
    logic [6:0]         key_count_reg;

    t_pose poses_due[$];
    int    mismatches = 0;
    bit    calm = 1'b0;   // set to run both sides without gaps

    keyframe_pose_interpolator dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #24000000;
        $display("tb_keyframe_pose_interpolator: errors");
        $finish;
    end

    // ---------------- pose arithmetic ----------------

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Degrees Q12.16 to radians Q6.26, round to nearest, saturate.
    function automatic logic signed [31:0] deg_to_rad(logic signed [27:0] d);
        longint v;
        v = (longint'(d) * DEG_MUL + 64'sd524288) >>> 20;
        return 32'(clip32(v));
    endfunction

    // Fold an angle into [-pi, pi].
    function automatic longint fold_pi(longint x);
        longint k;
        if (x > PI_L) begin
            k = (x - PI_L + TWOPI_L - 1) / TWOPI_L;
            x = x - k * TWOPI_L;
        end else if (x < -PI_L) begin
            k = (-PI_L - x + TWOPI_L - 1) / TWOPI_L;
            x = x + k * TWOPI_L;
        end
        return x;
    endfunction

    function automatic longint seg_fraction(logic [31:0] t, logic [31:0] t0, logic [31:0] t1);
        longint q;
        if (t1 <= t0 || t < t0) return 0;
        q = (longint'(t - t0) <<< 16) / longint'(t1 - t0);
        return (q > ONE_Q) ? ONE_Q : q;
    endfunction

    function automatic logic signed [31:0] blend_pos(logic signed [31:0] p0,
                                                     logic signed [31:0] p1, longint th);
        longint v;
        v = (ONE_Q - th) * longint'(p0) + th * longint'(p1) + 64'sd32768;
        return 32'(clip32(v >>> 16));
    endfunction

    function automatic logic signed [31:0] blend_ang(logic signed [31:0] a0,
                                                     logic signed [31:0] a1, longint th);
        longint da, a;
        da = fold_pi(longint'(a1) - longint'(a0));
        a  = longint'(a0) + ((th * da + 64'sd32768) >>> 16);
        return 32'(clip32(fold_pi(a)));
    endfunction

    // Pose at time t from the shadow table.
    function automatic t_pose pose_at(logic [31:0] t);
        t_pose r;
        int n, k, j;
        logic signed [31:0] p0 [3], p1 [3], a0 [3], a1 [3];
        logic [31:0] t0, t1;
        longint th;
        n = int'(key_count_reg);
        if (n < 1) n = 1;
        if (n > NKEYS) n = NKEYS;
        if (t >= key_time_tab[n-1]) begin
            for (j = 0; j < 3; j++) begin
                r[j]   = key_pos_tab[n-1][j];
                r[3+j] = key_rad_tab[n-1][j];
            end
            return r;
        end
        if (t <= key_time_tab[0]) begin
            for (j = 0; j < 3; j++) begin
                p0[j] = start_pos[j];  a0[j] = start_rad[j];
                p1[j] = key_pos_tab[0][j];  a1[j] = key_rad_tab[0][j];
            end
            t0 = '0;
            t1 = key_time_tab[0];
        end else begin
            k = 0;
            while (k < n - 2 && t >= key_time_tab[k+1]) k++;
            for (j = 0; j < 3; j++) begin
                p0[j] = key_pos_tab[k][j];    a0[j] = key_rad_tab[k][j];
                p1[j] = key_pos_tab[k+1][j];  a1[j] = key_rad_tab[k+1][j];
            end
            t0 = key_time_tab[k];
            t1 = key_time_tab[k+1];
        end
        th = seg_fraction(t, t0, t1);
        for (j = 0; j < 3; j++) begin
            r[j]   = blend_pos(p0[j], p1[j], th);
            r[3+j] = blend_ang(a0[j], a1[j], th);
        end
        return r;
    endfunction

    // ---------------- driving ----------------

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Send one beat; valid stays high afterwards so beats can go back to back.
    task automatic send_beat(logic act, logic [5:0] idx, logic [31:0] kt,
                             logic signed [31:0] kx, logic signed [31:0] ky,
                             logic signed [31:0] kz, logic signed [27:0] dr,
                             logic signed [27:0] dp, logic signed [27:0] dy,
                             logic [31:0] qt);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action <= act;           i_key_index <= idx;
        i_key_time <= kt;          i_query_time <= qt;
        i_key_x <= kx;             i_key_y <= ky;         i_key_z <= kz;
        i_key_roll_deg <= dr;      i_key_pitch_deg <= dp; i_key_yaw_deg <= dy;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // Beat taken: update the shadow state or queue the pose.
        if (act == kpi_pkg::ACT_LOAD) begin
            key_time_tab[idx]   = kt;
            key_pos_tab[idx][0] = kx;
            key_pos_tab[idx][1] = ky;
            key_pos_tab[idx][2] = kz;
            key_rad_tab[idx][0] = deg_to_rad(dr);
            key_rad_tab[idx][1] = deg_to_rad(dp);
            key_rad_tab[idx][2] = deg_to_rad(dy);
        end else begin
            poses_due.push_back(pose_at(qt));
        end
    endtask

    function automatic logic signed [27:0] rand_deg();
        case ($urandom_range(0, 3))
            0:       return 28'($urandom);   // full width, saturating cases too
            1:       return 28'($urandom_range(0, 94371840)) - 28'sd47185920;
            default: return $signed(28'($urandom_range(0, 2 * 94371840))) - 28'sd94371840;
        endcase
    endfunction

    task automatic load_key(logic [5:0] idx, logic [31:0] kt);
        send_beat(kpi_pkg::ACT_LOAD, idx, kt, $urandom, $urandom, $urandom,
                  rand_deg(), rand_deg(), rand_deg(), $urandom);
    endtask

    task automatic load_key_deg(logic [5:0] idx, logic [31:0] kt, logic signed [27:0] dr,
                                logic signed [27:0] dp, logic signed [27:0] dy);
        send_beat(kpi_pkg::ACT_LOAD, idx, kt, $urandom, $urandom, $urandom, dr, dp, dy,
                  $urandom);
    endtask

    task automatic query(logic [31:0] qt);
        send_beat(kpi_pkg::ACT_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                  28'($urandom), 28'($urandom), 28'($urandom), qt);
    endtask

    // Drop valid, wait for every pose, then let a trailing load retire.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (poses_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write; call only after settle().
    task automatic write_reg(kpi_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx) inside
            kpi_pkg::CFG_START_X, kpi_pkg::CFG_START_Y, kpi_pkg::CFG_START_Z:
                start_pos[2'(idx)] = data;
            kpi_pkg::CFG_START_ROLL, kpi_pkg::CFG_START_PITCH, kpi_pkg::CFG_START_YAW:
                start_rad[2'(idx - kpi_pkg::CFG_START_ROLL)] = data;
            kpi_pkg::CFG_KEY_COUNT: key_count_reg = data[6:0];
            default: ;
        endcase
        // Hold valid low for one cycle before the next write.
        @(posedge i_clk);
    endtask

    // Result side: random stall per beat, with calm stretches.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
    endtask

    // Compare each accepted pose with the oldest one awaited.
    always @(posedge i_clk) begin
        t_pose want, got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_yaw, o_pitch, o_roll, o_pos_z, o_pos_y, o_pos_x};
            if (poses_due.size() == 0) begin
                report("unexpected pose", '0, got[0]);
            end else begin
                want = poses_due.pop_front();
                if (want[0] !== got[0]) report("pos_x", want[0], got[0]);
                if (want[1] !== got[1]) report("pos_y", want[1], got[1]);
                if (want[2] !== got[2]) report("pos_z", want[2], got[2]);
                if (want[3] !== got[3]) report("roll", want[3], got[3]);
                if (want[4] !== got[4]) report("pitch", want[4], got[4]);
                if (want[5] !== got[5]) report("yaw", want[5], got[5]);
            end
        end
    end

    // ---------------- tests ----------------

    // Fill every slot with ascending times so no query reads an empty slot.
    task automatic test_fill_table();
        logic [31:0] t;
        t = 32'h0001_0000;
        for (int i = 0; i < NKEYS; i++) begin
            load_key(6'(i), t);
            t = t + 32'h0001_0000 + $urandom_range(0, 32'h0003_0000);
        end
    endtask

    // Single key (reset count), then count zero, 64 and above 64.
    task automatic test_key_count();
        query(32'h0000_0000);
        query(key_time_tab[0]);
        query(32'hFFFF_FFFF);
        query(key_time_tab[0] >> 1);
        settle();
        write_reg(kpi_pkg::CFG_KEY_COUNT, 32'd0);
        query(key_time_tab[0] - 1);
        settle();
        write_reg(kpi_pkg::CFG_KEY_COUNT, 32'd127);
        query(key_time_tab[NKEYS-1]);
        query(key_time_tab[NKEYS-1] - 1);
        settle();
        write_reg(kpi_pkg::CFG_KEY_COUNT, 32'd64);
        query(key_time_tab[31] + 32'h0000_8000);
        query(key_time_tab[62]);
    endtask

    // Start pose at both extremes, queried before the first key.
    task automatic test_start_pose();
        settle();
        write_reg(kpi_pkg::CFG_START_X, 32'h8000_0000);
        write_reg(kpi_pkg::CFG_START_Y, 32'h7FFF_FFFF);
        write_reg(kpi_pkg::CFG_START_Z, 32'hFFFF_FFFF);
        write_reg(kpi_pkg::CFG_START_ROLL, -32'sd1686629713);
        write_reg(kpi_pkg::CFG_START_PITCH, 32'sd1686629713);
        write_reg(kpi_pkg::CFG_START_YAW, 32'sd210828714);
        calm = 1'b1;
        query(32'h0);
        query(key_time_tab[0] >> 2);
        query(key_time_tab[0] - 1);
        calm = 1'b0;
    endtask

    // Angles across the +-180 degree seam, degree extremes, equal and falling times.
    task automatic test_angles_and_times();
        settle();
        write_reg(kpi_pkg::CFG_KEY_COUNT, 32'd4);
        load_key_deg(0, 32'h0010_0000, 28'sd11730944, -28'sd11730944, 28'sd0);
        load_key_deg(1, 32'h0020_0000, -28'sd11730944, 28'sd11730944, 28'sd94371840);
        load_key_deg(2, 32'h0020_0000, -28'sd94371840, 28'sh7FF_FFFF, -28'sh800_0000);
        load_key_deg(3, 32'h0018_0000, 28'sd0, 28'sd0, 28'sd0);
        query(32'h0018_0000);
        query(32'h001F_FFFF);
        query(32'h0020_0000);
        query(32'h0017_FFFF);
        query(32'h0008_0000);
    endtask

    // Rebuild part of the table with ascending times, then query around them.
    task automatic test_random(int items);
        int left, n, j;
        logic [31:0] t, qt;
        left = items;
        while (left > 0) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0:       write_reg(kpi_pkg::CFG_KEY_COUNT, $urandom_range(0, 127));
                1:       write_reg(kpi_pkg::CFG_KEY_COUNT, $urandom_range(1, 3));
                default: write_reg(kpi_pkg::CFG_KEY_COUNT, $urandom_range(2, 64));
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(kpi_pkg::t_cfg_idx'($urandom_range(0, 2)), $urandom);
                write_reg(kpi_pkg::t_cfg_idx'($urandom_range(3, 5)),
                          $urandom_range(0, 2 * 1686629713) - 1686629713);
            end
            n = int'(key_count_reg);
            if (n < 1) n = 1;
            if (n > NKEYS) n = NKEYS;
            t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - n * 32'h0001_0000
                                            : $urandom_range(0, 32'h00FF_FFFF);
            for (int i = 0; i < n; i++) begin
                load_key(6'(i), t);
                left--;
                if ($urandom_range(0, 15) != 0)
                    t = t + $urandom_range(0, (t[31:28] == 4'hF) ? 32'hFFFF : 32'h000F_FFFF);
            end
            for (int i = 0; i < 40 && left > 0; i++, left--) begin
                j = $urandom_range(0, n - 1);
                case ($urandom_range(0, 7))
                    0:       qt = $urandom;
                    1:       qt = key_time_tab[j];
                    2: begin
                        load_key(6'($urandom_range(0, NKEYS - 1)), $urandom);
                        qt = $urandom;
                    end
                    default: qt = key_time_tab[j] + $urandom_range(0, 32'h0004_0000)
                                  - 32'h0002_0000;
                endcase
                query(qt);
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            start_pos[i] = '0;
            start_rad[i] = '0;
        end
        key_count_reg = 7'd1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_table();
        test_key_count();
        test_start_pose();
        test_angles_and_times();
        test_random(400);

        settle();
        if (mismatches == 0 && poses_due.size() == 0) begin
            $display("tb_keyframe_pose_interpolator: clean");
        end else begin
            $display("tb_keyframe_pose_interpolator: errors");
        end
        $finish;
    end

endmodule
